// File: rtl/dnserb_pkg.sv
package dnserb_pkg;

  localparam int unsigned HeaderLen   = 12;
  localparam int unsigned TailLen     = 4;
  localparam int unsigned LabelMax    = 64;
  localparam int unsigned RcodeMax    = 5;
  localparam int unsigned MaxLenReset = 512;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAMELEN = 3'd1,
    PH_LABEL   = 3'd2,
    PH_TAIL    = 3'd3,
    PH_DROP    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RCODE = 3'd1,
    ST_LABEL     = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic {
    REG_RCODE   = 1'b0,
    REG_MAX_LEN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  rcode;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } res_t;

endpackage

// File: rtl/dnserb_cfg.sv
module dnserb_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output dnserb_pkg::cfg_t    cfg
);
  import dnserb_pkg::*;

  logic [3:0]  rcode_r;
  logic [15:0] max_len_r;

  assign cfg_ready   = 1'b1;
  assign cfg.rcode   = rcode_r;
  assign cfg.max_len = max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcode_r   <= 4'd0;
      max_len_r <= 16'(MaxLenReset);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RCODE:   rcode_r   <= cfg_data[3:0];
        REG_MAX_LEN: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/dnserb_parse.sv
module dnserb_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  input  dnserb_pkg::cfg_t    cfg,
  output logic                res_valid,
  output dnserb_pkg::res_t    res
);
  import dnserb_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  header_pos_r, header_pos_nxt;
  logic [5:0]  label_left_r, label_left_nxt;
  logic [2:0]  tail_left_r, tail_left_nxt;
  logic [15:0] out_count_r, out_count_nxt;

  logic [7:0]  ob;
  logic        done;
  logic        fin;
  status_t     err;
  logic [16:0] count_inc;

  assign count_inc = {1'b0, out_count_r} + 17'd1;

  // Result of the current byte.
  always_comb begin
    ob   = in_data;
    done = 1'b0;
    err  = ST_OK;
    unique case (phase_r)
      PH_HEADER: begin
        if (header_pos_r == 4'd2) begin
          ob = {1'b1, 6'd0, in_data[0]};
        end else if (header_pos_r == 4'd3) begin
          ob = {4'd0, cfg.rcode};
        end else if (header_pos_r >= 4'd6) begin
          ob = 8'd0;
        end
      end
      PH_NAMELEN: begin
        if (in_data != 8'd0 && in_data >= 8'(LabelMax)) begin
          err = ST_LABEL;
        end
      end
      PH_TAIL: begin
        done = (tail_left_r == 3'd1);
      end
      default: ;
    endcase
    if (err == ST_OK && in_last && !done) begin
      err = ST_TRUNC;
    end
    if (err == ST_OK && count_inc > {1'b0, cfg.max_len}) begin
      err = ST_TOO_LONG;
    end
    fin = done || (err != ST_OK);
    if (fin && cfg.rcode > 4'(RcodeMax)) begin
      err = ST_BAD_RCODE;
    end
    res_valid  = (phase_r != PH_DROP);
    res.data   = ob;
    res.last   = fin;
    res.status = fin ? err : ST_OK;
  end

  // Next state.
  always_comb begin
    phase_nxt      = phase_r;
    header_pos_nxt = header_pos_r;
    label_left_nxt = label_left_r;
    tail_left_nxt  = tail_left_r;
    out_count_nxt  = count_inc[15:0];
    unique case (phase_r)
      PH_HEADER: begin
        if (header_pos_r == 4'(HeaderLen - 1)) begin
          header_pos_nxt = 4'd0;
          phase_nxt      = PH_NAMELEN;
        end else begin
          header_pos_nxt = header_pos_r + 4'd1;
        end
      end
      PH_NAMELEN: begin
        if (in_data == 8'd0) begin
          tail_left_nxt = 3'(TailLen);
          phase_nxt     = PH_TAIL;
        end else if (in_data < 8'(LabelMax)) begin
          label_left_nxt = in_data[5:0];
          phase_nxt      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_left_nxt = label_left_r - 6'd1;
        if (label_left_r == 6'd1) begin
          phase_nxt = PH_NAMELEN;
        end
      end
      PH_TAIL: begin
        tail_left_nxt = tail_left_r - 3'd1;
      end
      PH_DROP: begin
        out_count_nxt = out_count_r;
      end
      default: ;
    endcase
    if ((phase_r == PH_DROP && in_last) || (phase_r != PH_DROP && fin)) begin
      phase_nxt      = (phase_r != PH_DROP && !in_last) ? PH_DROP : PH_HEADER;
      header_pos_nxt = 4'd0;
      label_left_nxt = 6'd0;
      tail_left_nxt  = 3'd0;
      out_count_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      header_pos_r <= 4'd0;
      label_left_r <= 6'd0;
      tail_left_r  <= 3'd0;
      out_count_r  <= 16'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      header_pos_r <= header_pos_nxt;
      label_left_r <= label_left_nxt;
      tail_left_r  <= tail_left_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    !res.last |-> res.status == ST_OK) else $error("status on non-final byte");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DROP |-> !res_valid) else $error("result while dropping");

  a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LABEL |-> label_left_r != 6'd0) else $error("empty label body");

endmodule

// File: rtl/dnserb_oreg.sv
module dnserb_oreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dnserb_pkg::res_t    push_res,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dnserb_pkg::res_t    out_res
);
  import dnserb_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt  = skid_valid_r;
      out_res_nxt    = skid_res_r;
      skid_valid_nxt = 1'b0;
    end
    if (push) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = push_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds data with output empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push) else $error("push into full output stage");

endmodule

// File: rtl/dns_error_response_builder.sv
// Channel  Direction  Signals                         Contents
// in_      input      tvalid tready tdata[7:0] tlast  query byte, final byte flag
// out_     output     tvalid tready tdata[7:0] tlast  response byte, final flag,
//                     tuser[2:0]                      status
// cfg_     input      valid ready index data[15:0]    index 0 rcode, 1 max length
//
// One query byte is accepted per cycle while in_tready is high; its response
// byte, if any, is registered and leaves from the output register. A second
// register behind the output keeps the input flowing while the output stalls,
// until it too holds a byte; then in_tready stays low until the output
// register hands on a response byte. Reset is synchronous and clears the
// parser state, the output stage and the registers to rcode 0 and length 512.
module dns_error_response_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dnserb_pkg::*;

  cfg_t cfg;
  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign accept = in_tvalid && in_tready;

  dnserb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dnserb_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  dnserb_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_res  (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.status;

endmodule
